/* hw/rtl/size_class_free_list_pool_assert.svh */
// Assertion macros shared by the RTL of the size-class free-list pool.
`ifndef SIZE_CLASS_FREE_LIST_POOL_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_POOL_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SCFLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SCFLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/scflp_pkg.sv */
// ----------------------------------------------------------------------------
// Size-class free-list pool package
// Sizes, widths, register indexes and outcome codes of the free-list pool.
// ----------------------------------------------------------------------------
package scflp_pkg;

    localparam int NUM_CLASSES = 32;
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_WIDTH  = 32;

    localparam int CLASS_W  = 5;
    localparam int STRIDE_W = 16;
    localparam int FADDR_W  = 32;
    localparam int BYTES_W  = 48;
    localparam int CBYTES_W = 32;
    localparam int THR_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int CLS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int STK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_ADDR_W = CLS_IDX_W + STK_IDX_W;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [FADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= FADDR_W) ? '1 :
        FADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    localparam logic [CBYTES_W-1:0] MAX_BYTES_RESET = CBYTES_W'(1 << 20);
    localparam logic [THR_W-1:0]    LARGE_THR_RESET = THR_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_BYTES = 2'd0,
        REG_LARGE_THR = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OC_REUSE   = 2'd0,
        OC_FRESH   = 2'd1,
        OC_CACHED  = 2'd2,
        OC_RELEASE = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [CBYTES_W-1:0] bytes;
    } meta_t;

endpackage

/* hw/rtl/size_class_free_list_pool.sv */
// ----------------------------------------------------------------------------
// Size-class free-list pool
// Per-class LIFO stacks of free block addresses with entry counts and byte
// totals, answering one alloc or free request at a time.
// ----------------------------------------------------------------------------
// Order: a free or a fresh alloc gives its result after the class metadata read,
// a reuse alloc after the class metadata read and then the stack read.
// One item at a time: busy is high while an item is in progress and no new item is
// taken then; a new item may be started in the cycle that shows the result.
// The receiver cannot stall: each result is shown for one cycle under done.
// Reset clears the class metadata valid bits and restores register defaults.
module size_class_free_list_pool (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic [scflp_pkg::CLASS_W-1:0]      size_class,
    input  logic [scflp_pkg::STRIDE_W-1:0]     stride,
    input  logic [scflp_pkg::FADDR_W-1:0]      block_address,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [scflp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scflp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                               done,
    output scflp_pkg::outcome_t                outcome,
    output logic [scflp_pkg::FADDR_W-1:0]      result_address,
    output logic [scflp_pkg::BYTES_W-1:0]      block_bytes
);
    import scflp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_POP
    } state_t;

    state_t                 state_reg;
    logic                   done_reg;
    outcome_t               outcome_reg;
    logic [FADDR_W-1:0]     res_addr_reg;

    logic [CBYTES_W-1:0]    max_bytes_reg;
    logic [THR_W-1:0]       large_thr_reg;

    logic                   is_free_reg;
    logic [CLASS_W-1:0]     cls_reg;
    logic [FADDR_W-1:0]     addr_reg;
    logic [BYTES_W-1:0]     size_reg;

    meta_t                  meta_mem [2**CLS_IDX_W];
    meta_t                  meta_rd_reg;
    logic [2**CLS_IDX_W-1:0] meta_vld_reg;
    logic                   meta_hit_reg;

    logic [FADDR_W-1:0]     stack_mem [2**STK_ADDR_W];
    logic [FADDR_W-1:0]     stk_rd_reg;

    logic                   accept;
    logic [CLS_IDX_W-1:0]   in_idx;
    logic [CLS_IDX_W-1:0]   cls_idx;
    logic                   valid_class;
    logic [CNT_W-1:0]       cur_count;
    logic [CBYTES_W-1:0]    cur_bytes;
    logic [BYTES_W:0]       sum_bytes;
    logic                   over_budget;
    logic                   stack_full;
    logic                   do_pop;
    logic                   do_push;
    logic                   meta_we;
    meta_t                  meta_wdata;
    logic [CNT_W-1:0]       pop_count;
    logic [STK_ADDR_W-1:0]  push_addr;
    logic [STK_ADDR_W-1:0]  pop_addr;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done           = done_reg;
    assign outcome        = outcome_reg;
    assign result_address = res_addr_reg;
    assign block_bytes    = size_reg;

    assign in_idx  = size_class[CLS_IDX_W-1:0];
    assign cls_idx = cls_reg[CLS_IDX_W-1:0];

    always_comb
    begin
        valid_class = ({1'b0, cls_reg} < (CLASS_W+1)'(NUM_CLASSES));
        cur_count   = meta_hit_reg ? meta_rd_reg.count : '0;
        cur_bytes   = meta_hit_reg ? meta_rd_reg.bytes : '0;
        sum_bytes   = (BYTES_W+1)'(cur_bytes) + (BYTES_W+1)'(size_reg);
        over_budget = sum_bytes > (BYTES_W+1)'(max_bytes_reg);
        stack_full  = cur_count >= CNT_W'(STACK_DEPTH);
        pop_count   = cur_count - CNT_W'(1);
        do_pop  = !is_free_reg && valid_class && (cur_count != '0);
        do_push = is_free_reg && valid_class && ({1'b0, cls_reg} < large_thr_reg)
                  && !over_budget && !stack_full;
        meta_we = (state_reg == S_META) && (do_pop || do_push);
        if (do_pop)
        begin
            meta_wdata.count = pop_count;
            meta_wdata.bytes = ((BYTES_W)'(cur_bytes) >= size_reg) ?
                               (cur_bytes - size_reg[CBYTES_W-1:0]) : '0;
        end
        else
        begin
            meta_wdata.count = cur_count + CNT_W'(1);
            meta_wdata.bytes = sum_bytes[CBYTES_W-1:0];
        end
        push_addr = {cls_idx, cur_count[STK_IDX_W-1:0]};
        pop_addr  = {cls_idx, pop_count[STK_IDX_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
            large_thr_reg <= LARGE_THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MAX_BYTES)
            begin
                max_bytes_reg <= cfg_data[CBYTES_W-1:0];
            end
            else if (cfg_index == REG_LARGE_THR)
            begin
                large_thr_reg <= cfg_data[THR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_vld_reg <= '0;
        end
        else if (meta_we)
        begin
            meta_vld_reg[cls_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[cls_idx] <= meta_wdata;
        end
        if (accept)
        begin
            meta_rd_reg  <= meta_mem[in_idx];
            meta_hit_reg <= meta_vld_reg[in_idx];
            is_free_reg  <= req_type;
            cls_reg      <= size_class;
            addr_reg     <= block_address & ADDR_MASK;
            size_reg     <= BYTES_W'(stride) << size_class;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_META) && do_push)
        begin
            stack_mem[push_addr] <= addr_reg;
        end
        if ((state_reg == S_META) && do_pop)
        begin
            stk_rd_reg <= stack_mem[pop_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            outcome_reg  <= OC_FRESH;
            res_addr_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_META;
                    end
                end
                S_META:
                begin
                    if (do_pop)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                        if (!is_free_reg)
                        begin
                            outcome_reg  <= OC_FRESH;
                            res_addr_reg <= '0;
                        end
                        else
                        begin
                            outcome_reg  <= do_push ? OC_CACHED : OC_RELEASE;
                            res_addr_reg <= addr_reg;
                        end
                    end
                end
                S_POP:
                begin
                    state_reg    <= S_IDLE;
                    done_reg     <= 1'b1;
                    outcome_reg  <= OC_REUSE;
                    res_addr_reg <= stk_rd_reg & ADDR_MASK;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "size_class_free_list_pool_assert.svh"

    `SCFLP_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
    `SCFLP_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
    `SCFLP_ASSERT_NEXT(a_pop_reuse, state_reg == S_POP, done && (outcome == OC_REUSE),
        "stack read did not end in a reuse result")
    `SCFLP_ASSERT_NEXT(a_meta_write_once, meta_we, !meta_we,
        "class metadata written twice for one item")

endmodule
